[rtl/pps_pkg.sv]
package pps_pkg;

  localparam int unsigned MaxPrimesDef = 64;
  localparam int unsigned ValueBitsDef = 16;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_READ,
    BS_DIV,
    BS_DECIDE
  } back_state_e;

endpackage

[rtl/pps_front.sv]
module pps_front import pps_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output logic [VALUE_BITS-1:0] item_value_o,
  output logic                  item_last_o
);

  logic                  valid_q, valid_d;
  logic [VALUE_BITS-1:0] value_q;
  logic                  last_q;
  logic                  take;

  assign in_ready_o = !valid_q || item_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (item_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      value_q <= value_i;
      last_q  <= last_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_value_o = value_q;
  assign item_last_o  = last_q;

endmodule

[rtl/pps_queue.sv]
module pps_queue import pps_pkg::*; #(
  parameter int unsigned WIDTH = ValueBitsDef + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0] entry_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/pps_back.sv]
module pps_back import pps_pkg::*; #(
  parameter int unsigned MAX_PRIMES = MaxPrimesDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  logic [VALUE_BITS-1:0] item_value_i,
  input  logic                  item_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] prime_o,
  output logic                  overflow_o
);

  localparam int unsigned CntW  = $clog2(MAX_PRIMES + 1);
  localparam int unsigned IdxW  = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int unsigned StepW = $clog2(VALUE_BITS);

  back_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mem [MAX_PRIMES];
  logic [VALUE_BITS-1:0] rdata_q;
  logic [IdxW-1:0]       rd_addr;
  logic                  wr_en;

  logic [VALUE_BITS-1:0] cand_q, cand_d;
  logic                  last_q, last_d;
  logic                  survive_q, survive_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic [VALUE_BITS-1:0] dvd_q, dvd_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [StepW-1:0]      step_q, step_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] prime_q, prime_d;
  logic                  ovf_q, ovf_d;

  logic [VALUE_BITS:0]   shifted, diff;
  logic [VALUE_BITS-1:0] rem_nx;
  logic                  out_free;
  logic [CntW-1:0]       idx_inc;

  // one restoring remainder step per cycle, a zero divisor leaves the dividend
  assign shifted  = {rem_q, dvd_q[VALUE_BITS-1]};
  assign diff     = shifted - {1'b0, div_q};
  assign rem_nx   = (shifted >= {1'b0, div_q}) ? diff[VALUE_BITS-1:0]
                                               : shifted[VALUE_BITS-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign idx_inc  = idx_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (item_valid_i) begin
          state_d = (cnt_q == '0) ? BS_DECIDE : BS_READ;
        end
      end
      BS_READ: state_d = BS_DIV;
      BS_DIV: begin
        if (step_q == '0) begin
          if (rem_nx == '0 || idx_inc == cnt_q) begin
            state_d = BS_DECIDE;
          end else begin
            state_d = BS_READ;
          end
        end
      end
      BS_DECIDE: begin
        if (!survive_q || out_free) begin
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    cand_d       = cand_q;
    last_d       = last_q;
    survive_d    = survive_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    div_d        = div_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    step_d       = step_q;
    prime_d      = prime_q;
    ovf_d        = ovf_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    wr_en        = 1'b0;
    item_ready_o = 1'b0;
    unique case (state_q)
      BS_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cand_d    = item_value_i;
          last_d    = item_last_i;
          survive_d = 1'b1;
          idx_d     = '0;
        end
      end
      BS_READ: begin
        div_d  = rdata_q;
        dvd_d  = cand_q;
        rem_d  = '0;
        step_d = StepW'(VALUE_BITS - 1);
      end
      BS_DIV: begin
        rem_d  = rem_nx;
        dvd_d  = dvd_q << 1;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          if (rem_nx == '0) begin
            survive_d = 1'b0;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      BS_DECIDE: begin
        if (survive_q && out_free) begin
          out_valid_d = 1'b1;
          prime_d     = cand_q;
          ovf_d       = cnt_q == CntW'(MAX_PRIMES);
          if (cnt_q != CntW'(MAX_PRIMES)) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        if ((!survive_q || out_free) && last_q) begin
          cnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  assign rd_addr = idx_d[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IdxW-1:0]] <= cand_q;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q    <= cand_d;
    last_q    <= last_d;
    survive_q <= survive_d;
    idx_q     <= idx_d;
    div_q     <= div_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    step_q    <= step_d;
    prime_q   <= prime_d;
    ovf_q     <= ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign prime_o     = prime_q;
  assign overflow_o  = ovf_q;

endmodule

[rtl/pipelined_prime_sieve.sv]
// flow: an item passes the front register and the queue; the back end then reads each stored
// prime and divides the item by it until a divisor is found or the list ends
// the back end takes one item at a time, limited by the shared bit-serial remainder
// unit and the single read port of the prime store; the front and queue buffer later items
// reset: asynchronous, active low; clears the list count, queue and handshakes,
// the store itself is not cleared
module pipelined_prime_sieve import pps_pkg::*; #(
  parameter int unsigned MAX_PRIMES = MaxPrimesDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] prime_o,
  output logic                  overflow_o
);

  logic                  fr_valid, fr_ready;
  logic [VALUE_BITS-1:0] fr_value;
  logic                  fr_last;
  logic                  q_valid, q_ready;
  logic [VALUE_BITS:0]   q_data;

  pps_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .last_i      (last_i),
    .item_valid_o(fr_valid),
    .item_ready_i(fr_ready),
    .item_value_o(fr_value),
    .item_last_o (fr_last)
  );

  pps_queue #(
    .WIDTH(VALUE_BITS + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_data_i ({fr_last, fr_value}),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_data)
  );

  pps_back #(
    .MAX_PRIMES(MAX_PRIMES),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_ready_o(q_ready),
    .item_value_i(q_data[VALUE_BITS-1:0]),
    .item_last_i (q_data[VALUE_BITS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .prime_o     (prime_o),
    .overflow_o  (overflow_o)
  );

endmodule
